[src/uer_pkg.sv]
`timescale 1ns / 1ps

package uer_pkg;

   localparam int COUNTER_BITS = 16;
   localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
   localparam int SCALE_BITS = 18;
   localparam int DIST_BITS = 17;
   localparam int PROD_BITS = COUNTER_BITS + SCALE_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 18;

   localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
   localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(32768);

   localparam logic [7:0] PRE_LOW_RESET = 8'd2;
   localparam logic [7:0] TRIGGER_RESET = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 18'd112394;
   localparam logic [DIST_BITS-1:0] TIMEOUT_DIST_RESET = 17'd99900;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PRE_LOW      = 3'd0,
      CSR_TRIGGER      = 3'd1,
      CSR_TIMEOUT      = 3'd2,
      CSR_SCALE        = 3'd3,
      CSR_TIMEOUT_DIST = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRE  = 3'd1,
      PH_TRIG = 3'd2,
      PH_RISE = 3'd3,
      PH_HIGH = 3'd4
   } phase_type;

   typedef struct packed {
      logic echo_level;
      logic start_request;
   } req_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 busy_res;
      logic                 done_res;
      logic                 timed_out;
      logic [DIST_BITS-1:0] distance_centi_cm;
   } rsp_type;

endpackage

[src/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps

// Ultrasonic echo ranger. Each request beat is one microsecond tick carrying the sampled echo
// level and a start request; each accepted beat yields exactly one response beat giving the
// trigger pin level, busy, done, timed_out and the latest distance in hundredths of a cm.
// A start while idle holds trigger low for pre_low_ticks, high for trigger_ticks, then waits for
// the echo to rise and times its high width; either wait ends after timeout_ticks with
// timed_out set and timeout_distance reported. One beat is accepted every cycle unless stalled:
// the phase, tick counter and the 16x18 distance multiply are all combinational into the
// response register, whose beat appears the cycle after acceptance. While a response beat is
// stalled, req_stall stays high and the next request beat waits.
// Write the csr_ registers only while no measurement is running.
module ultrasonic_echo_ranger (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  uer_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output uer_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_we,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   logic [7:0]                          pre_low_ff;
   logic [7:0]                          trigger_ff;
   logic [15:0]                         timeout_ff;
   logic [uer_pkg::SCALE_BITS-1:0]      scale_ff;
   logic [uer_pkg::DIST_BITS-1:0]       timeout_dist_ff;

   uer_pkg::phase_type                  phase_ff, phase_in;
   logic [uer_pkg::COUNTER_BITS-1:0]    count_ff, count_in;
   logic [uer_pkg::DIST_BITS-1:0]       dist_ff, dist_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   uer_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic                                accept;
   logic [uer_pkg::COUNTER_BITS-1:0]    bumped;
   logic [uer_pkg::CMP_BITS-1:0]        bumped_cmp;
   logic                                pre_hit, trig_hit, expired_hit;
   logic                                done, tout;
   logic [uer_pkg::PROD_BITS-1:0]       product;
   logic [uer_pkg::PROD_BITS:0]         rounded;
   logic [uer_pkg::PROD_BITS-16:0]      scaled;
   logic [uer_pkg::DIST_BITS-1:0]       measured;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_low_ff <= uer_pkg::PRE_LOW_RESET;
         trigger_ff <= uer_pkg::TRIGGER_RESET;
         timeout_ff <= uer_pkg::TIMEOUT_RESET;
         scale_ff <= uer_pkg::SCALE_RESET;
         timeout_dist_ff <= uer_pkg::TIMEOUT_DIST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            uer_pkg::CSR_PRE_LOW:      pre_low_ff <= csr_wdata[7:0];
            uer_pkg::CSR_TRIGGER:      trigger_ff <= csr_wdata[7:0];
            uer_pkg::CSR_TIMEOUT:      timeout_ff <= csr_wdata[15:0];
            uer_pkg::CSR_SCALE:        scale_ff <= csr_wdata[uer_pkg::SCALE_BITS-1:0];
            uer_pkg::CSR_TIMEOUT_DIST: timeout_dist_ff <= csr_wdata[uer_pkg::DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   // saturating counter step and the compares shared by the done, next-phase and counter blocks
   assign bumped = (count_ff < uer_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign bumped_cmp = uer_pkg::CMP_BITS'(bumped);
   assign pre_hit = bumped_cmp >= uer_pkg::CMP_BITS'(pre_low_ff);
   assign trig_hit = bumped_cmp >= uer_pkg::CMP_BITS'(trigger_ff);
   assign expired_hit = (bumped_cmp > uer_pkg::CMP_BITS'(timeout_ff))
                        || (bumped == uer_pkg::COUNT_MAX);

   assign product = uer_pkg::PROD_BITS'(count_ff) * uer_pkg::PROD_BITS'(scale_ff);
   assign rounded = {1'b0, product} + uer_pkg::ROUND_HALF;
   assign scaled = rounded[uer_pkg::PROD_BITS:16];
   assign measured = (scaled > (uer_pkg::PROD_BITS - 15)'(uer_pkg::DIST_MAX))
                     ? uer_pkg::DIST_MAX : uer_pkg::DIST_BITS'(scaled);

   always_comb begin
      done = 1'b0;
      tout = 1'b0;
      case (phase_ff)
         uer_pkg::PH_RISE: begin
            if (!req_data.echo_level && expired_hit) begin
               done = 1'b1;
               tout = 1'b1;
            end
         end
         uer_pkg::PH_HIGH: begin
            done = 1'b1;
            tout = req_data.echo_level && expired_hit;
            if (req_data.echo_level && !expired_hit) done = 1'b0;
         end
         default: ;
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (req_data.start_request)
               phase_in = (pre_low_ff == 8'd0) ? uer_pkg::PH_TRIG : uer_pkg::PH_PRE;
         end
         uer_pkg::PH_PRE:  if (pre_hit) phase_in = uer_pkg::PH_TRIG;
         uer_pkg::PH_TRIG: if (trig_hit) phase_in = uer_pkg::PH_RISE;
         uer_pkg::PH_RISE: if (req_data.echo_level) phase_in = uer_pkg::PH_HIGH;
         uer_pkg::PH_HIGH: ;
         default: phase_in = uer_pkg::PH_IDLE;
      endcase
      if (done) phase_in = uer_pkg::PH_IDLE;
   end

   // counter, distance and response fields
   always_comb begin
      count_in = count_ff;
      dist_in = dist_ff;
      case (phase_ff)
         uer_pkg::PH_IDLE: if (req_data.start_request) count_in = '0;
         uer_pkg::PH_PRE:  count_in = pre_hit ? '0 : bumped;
         uer_pkg::PH_TRIG: count_in = trig_hit ? '0 : bumped;
         uer_pkg::PH_RISE:
            count_in = req_data.echo_level ? uer_pkg::COUNTER_BITS'(1) : bumped;
         uer_pkg::PH_HIGH: begin
            count_in = bumped;
            if (!req_data.echo_level) dist_in = measured;
         end
         default: count_in = '0;
      endcase
      if (done) count_in = '0;
      if (tout) dist_in = timeout_dist_ff;

      rsp_data_in.trigger_level = (phase_in == uer_pkg::PH_TRIG);
      rsp_data_in.busy_res = (phase_in != uer_pkg::PH_IDLE);
      rsp_data_in.done_res = done;
      rsp_data_in.timed_out = tout;
      rsp_data_in.distance_centi_cm = dist_in;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         count_ff <= '0;
         dist_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            dist_ff <= dist_in;
         end
      end
   end

   // hold the response while stalled
   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule

[src/uer_checker.sv]
`timescale 1ns / 1ps

module uer_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input uer_pkg::rsp_type rsp_data
);

   // a finished measurement leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done beat reports busy");

   a_tout_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |-> rsp_data.done_res)
      else $error("timeout without done");

   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trigger_level |-> rsp_data.busy_res)
      else $error("trigger high while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
